[hdl/adlfr_pkg.sv]
// ----------------------------------------------------------------------------
// adlfr_pkg
// Types and constants shared by the Adler-32 checked frame receiver.
// ----------------------------------------------------------------------------
package adlfr_pkg;

    localparam int unsigned CFG_LEN_W = 27;
    localparam int unsigned TAG_LEN_W = 4;
    localparam int unsigned TAG_VAL_W = 64;

    localparam logic [15:0] ADLER_MOD = 16'd65521;
    localparam logic [2:0]  SUM_BYTES = 3'd4;
    localparam logic [1:0]  LAST_FIELD_BYTE = 2'd3;

    localparam logic [CFG_LEN_W-1:0] MIN_LENGTH_RST = 27'd4;
    localparam logic [CFG_LEN_W-1:0] MAX_LENGTH_RST = 27'd67108864;

    typedef enum logic [1:0] {
        PH_LEN  = 2'd0,
        PH_BODY = 2'd1,
        PH_SUM  = 2'd2,
        PH_LOCK = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEN  = 2'd1,
        ST_BAD_SUM  = 2'd2,
        ST_BAD_TYPE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_MIN_LENGTH = 2'd0,
        CFG_MAX_LENGTH = 2'd1,
        CFG_TAG_LENGTH = 2'd2,
        CFG_TAG_VALUE  = 2'd3
    } cfg_index_t;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef struct packed {
        logic [CFG_LEN_W-1:0] min_length;
        logic [CFG_LEN_W-1:0] max_length;
        logic [TAG_LEN_W-1:0] tag_length;
        logic [TAG_VAL_W-1:0] tag_value;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic       kind;
        logic [7:0] payload_byte;
        status_t    status;
    } result_t;

endpackage

[hdl/adler32_checked_frame_receiver_core.sv]
// Path from input beat to result beat: input register, then result register.
// Throughput: one byte per cycle unless a waiting result holds the stages; the Adler-32 update
// and frame checks sit between the input register and the result register.
// A waiting result holds both stages; a byte is taken then only into an empty input register.
// Reset: synchronous, active-low aresetn clears framing state and restores register defaults.
// ----------------------------------------------------------------------------
// adler32_checked_frame_receiver_core
// Length-prefixed frame receiver with Adler-32 check, top level.
// ----------------------------------------------------------------------------
module adler32_checked_frame_receiver_core #(
    parameter int unsigned MAX_TAG_BYTES = 8,
    parameter int unsigned LENGTH_BITS   = 27
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] new_connection
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [9:8] status, [15:10] zero
    output logic        m_axis_tuser,   // [0] kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import adlfr_pkg::*;

    cfg_t        cfg;
    result_t     result;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_newconn_reg;
    logic        out_valid_reg;
    logic        out_kind_reg;
    logic [7:0]  out_byte_reg;
    status_t     out_status_reg;
    logic        advance;
    logic        step;

    adlfr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    adlfr_frame_ctrl #(
        .MAX_TAG_BYTES (MAX_TAG_BYTES),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (step),
        .data_byte      (in_byte_reg),
        .new_connection (in_newconn_reg),
        .cfg            (cfg),
        .result         (result)
    );

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {6'd0, out_status_reg, out_byte_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg    <= s_axis_tdata;
            in_newconn_reg <= s_axis_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= step && result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && result.valid) begin
            out_kind_reg   <= result.kind;
            out_byte_reg   <= result.payload_byte;
            out_status_reg <= result.status;
        end
    end

endmodule

[hdl/adlfr_cfg_regs.sv]
// ----------------------------------------------------------------------------
// adlfr_cfg_regs
// Configuration register file: bounds, tag length and expected tag.
// ----------------------------------------------------------------------------
module adlfr_cfg_regs (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [63:0]            cfg_data,
    output adlfr_pkg::cfg_t        cfg
);
    import adlfr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_MIN_LENGTH: cfg_next.min_length = cfg_data[CFG_LEN_W-1:0];
                CFG_MAX_LENGTH: cfg_next.max_length = cfg_data[CFG_LEN_W-1:0];
                CFG_TAG_LENGTH: cfg_next.tag_length = cfg_data[TAG_LEN_W-1:0];
                CFG_TAG_VALUE:  cfg_next.tag_value  = cfg_data[TAG_VAL_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_length <= MIN_LENGTH_RST;
            cfg_reg.max_length <= MAX_LENGTH_RST;
            cfg_reg.tag_length <= '0;
            cfg_reg.tag_value  <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[hdl/adlfr_adler_step.sv]
// ----------------------------------------------------------------------------
// adlfr_adler_step
// One-byte Adler-32 update using conditional subtracts of the modulus.
// ----------------------------------------------------------------------------
module adlfr_adler_step (
    input  logic [15:0] low_in,
    input  logic [15:0] high_in,
    input  logic [7:0]  data_byte,
    output logic [15:0] low_out,
    output logic [15:0] high_out
);
    import adlfr_pkg::*;

    logic [16:0] low_sum;
    logic [16:0] high_sum;

    always_comb begin
        low_sum = {1'b0, low_in} + {9'd0, data_byte};
        if (low_sum >= {1'b0, ADLER_MOD}) begin
            low_sum = low_sum - {1'b0, ADLER_MOD};
        end
        low_out = low_sum[15:0];

        high_sum = {1'b0, high_in} + {1'b0, low_out};
        if (high_sum >= {1'b0, ADLER_MOD}) begin
            high_sum = high_sum - {1'b0, ADLER_MOD};
        end
        high_out = high_sum[15:0];
    end

endmodule

[hdl/adlfr_frame_ctrl.sv]
// ----------------------------------------------------------------------------
// adlfr_frame_ctrl
// Framing state machine: length check, Adler-32, tag compare, status.
// ----------------------------------------------------------------------------
module adlfr_frame_ctrl #(
    parameter int unsigned MAX_TAG_BYTES = 8,
    parameter int unsigned LENGTH_BITS   = 27
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [7:0]          data_byte,
    input  logic                new_connection,
    input  adlfr_pkg::cfg_t     cfg,
    output adlfr_pkg::result_t  result
);
    import adlfr_pkg::*;

    localparam logic [TAG_LEN_W-1:0] TAG_SAT = TAG_LEN_W'(MAX_TAG_BYTES);

    phase_t                 phase_reg, phase_next, phase_cur;
    logic [31:0]            lshift_reg, lshift_next, lshift_cur;
    logic [LENGTH_BITS-1:0] blen_reg, blen_next, blen_cur;
    logic [LENGTH_BITS-1:0] count_reg, count_next, count_cur;
    logic [15:0]            alow_reg, alow_next, alow_cur;
    logic [15:0]            ahigh_reg, ahigh_next, ahigh_cur;
    logic [31:0]            rsum_reg, rsum_next, rsum_cur;
    logic                   tagok_reg, tagok_next, tagok_cur;

    logic [15:0]            alow_upd;
    logic [15:0]            ahigh_upd;
    logic [TAG_LEN_W-1:0]   tag_bytes;
    logic [31:0]            len_word;
    logic                   len_bad;
    logic [LENGTH_BITS-1:0] count_inc;
    logic [TAG_LEN_W-1:0]   tag_pos;
    logic [2:0]             tag_idx;
    logic [7:0]             tag_want;
    status_t                code;

    adlfr_adler_step u_adler (
        .low_in    (alow_cur),
        .high_in   (ahigh_cur),
        .data_byte (data_byte),
        .low_out   (alow_upd),
        .high_out  (ahigh_upd)
    );

    assign tag_bytes = (cfg.tag_length > TAG_SAT) ? TAG_SAT : cfg.tag_length;

    always_comb begin
        // new connection drops any partial frame
        if (new_connection) begin
            phase_cur  = PH_LEN;
            lshift_cur = '0;
            blen_cur   = '0;
            count_cur  = '0;
            alow_cur   = 16'd1;
            ahigh_cur  = '0;
            rsum_cur   = '0;
            tagok_cur  = 1'b1;
        end else begin
            phase_cur  = phase_reg;
            lshift_cur = lshift_reg;
            blen_cur   = blen_reg;
            count_cur  = count_reg;
            alow_cur   = alow_reg;
            ahigh_cur  = ahigh_reg;
            rsum_cur   = rsum_reg;
            tagok_cur  = tagok_reg;
        end

        len_word  = {lshift_cur[23:0], data_byte};
        count_inc = count_cur + LENGTH_BITS'(1);
        len_bad   = ((len_word >> LENGTH_BITS) != 32'd0)
                 || (len_word < {5'd0, cfg.min_length})
                 || (len_word > {5'd0, cfg.max_length})
                 || (len_word < ({28'd0, tag_bytes} + {29'd0, SUM_BYTES}));

        tag_pos  = tag_bytes - TAG_LEN_W'(1) - count_cur[TAG_LEN_W-1:0];
        tag_idx  = tag_pos[2:0];
        tag_want = cfg.tag_value[{tag_idx, 3'b000} +: 8];

        if ({rsum_cur[23:0], data_byte} != {ahigh_cur, alow_cur}) begin
            code = ST_BAD_SUM;
        end else if (!tagok_cur) begin
            code = ST_BAD_TYPE;
        end else begin
            code = ST_OK;
        end

        phase_next  = phase_cur;
        lshift_next = lshift_cur;
        blen_next   = blen_cur;
        count_next  = count_cur;
        alow_next   = alow_cur;
        ahigh_next  = ahigh_cur;
        rsum_next   = rsum_cur;
        tagok_next  = tagok_cur;

        result.valid        = 1'b0;
        result.kind         = KIND_PAYLOAD;
        result.payload_byte = '0;
        result.status       = ST_OK;

        case (phase_cur)
            PH_LEN: begin
                lshift_next = len_word;
                count_next  = count_inc;
                if (count_cur[1:0] == LAST_FIELD_BYTE) begin
                    count_next = '0;
                    if (len_bad) begin
                        phase_next    = PH_LOCK;
                        result.valid  = 1'b1;
                        result.kind   = KIND_STATUS;
                        result.status = ST_BAD_LEN;
                    end else begin
                        blen_next  = len_word[LENGTH_BITS-1:0];
                        phase_next = (len_word == {29'd0, SUM_BYTES}) ? PH_SUM : PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                alow_next  = alow_upd;
                ahigh_next = ahigh_upd;
                if (count_cur < {{(LENGTH_BITS-TAG_LEN_W){1'b0}}, tag_bytes}) begin
                    if (tag_want != data_byte) begin
                        tagok_next = 1'b0;
                    end
                end else begin
                    result.valid        = 1'b1;
                    result.kind         = KIND_PAYLOAD;
                    result.payload_byte = data_byte;
                end
                count_next = count_inc;
                if (count_inc >= blen_cur - LENGTH_BITS'(SUM_BYTES)) begin
                    phase_next = PH_SUM;
                    count_next = '0;
                end
            end
            PH_SUM: begin
                rsum_next  = {rsum_cur[23:0], data_byte};
                count_next = count_inc;
                if (count_cur[1:0] == LAST_FIELD_BYTE) begin
                    result.valid  = 1'b1;
                    result.kind   = KIND_STATUS;
                    result.status = code;
                    phase_next    = (code == ST_OK) ? PH_LEN : PH_LOCK;
                    lshift_next   = '0;
                    blen_next     = '0;
                    count_next    = '0;
                    alow_next     = 16'd1;
                    ahigh_next    = '0;
                    rsum_next     = '0;
                    tagok_next    = 1'b1;
                end
            end
            PH_LOCK: begin
                phase_next = PH_LOCK;
            end
            default: begin
                phase_next = PH_LOCK;
            end
        endcase

        if (!step) begin
            result.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_LEN;
            lshift_reg <= '0;
            blen_reg   <= '0;
            count_reg  <= '0;
            alow_reg   <= 16'd1;
            ahigh_reg  <= '0;
            rsum_reg   <= '0;
            tagok_reg  <= 1'b1;
        end else if (step) begin
            phase_reg  <= phase_next;
            lshift_reg <= lshift_next;
            blen_reg   <= blen_next;
            count_reg  <= count_next;
            alow_reg   <= alow_next;
            ahigh_reg  <= ahigh_next;
            rsum_reg   <= rsum_next;
            tagok_reg  <= tagok_next;
        end
    end

endmodule
